>>> hdl/rbpd_pkg.sv
package rbpd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // column address into the coverage store
    localparam int COL_AW = $clog2(MAX_WIDTH);
    // rows, columns and coverage depths, including the value equal to the size
    localparam int DIM_W  = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = CFG_W'(480);

    typedef struct packed {
        logic [7:0] brush_width;
        logic [7:0] brush_height;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rbpd_in_t;

    typedef struct packed {
        logic [11:0] fill_row;
        logic [11:0] fill_col;
        logic [7:0]  fill_width;
        logic [7:0]  fill_height;
        logic [7:0]  fill_red;
        logic [7:0]  fill_green;
        logic [7:0]  fill_blue;
        logic        frame_end;
    } rbpd_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEEK_INIT,
        ST_SEEK_RD,
        ST_SEEK_CHK,
        ST_PLACE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_OUT
    } rbpd_state_t;

    typedef struct packed {
        logic take;
        logic seek_init;
        logic seek_chk;
        logic clr_step;
        logic place;
        logic upd_rd;
        logic upd_wr;
        logic out_load;
        logic frame_end;
    } rbpd_cmd_t;

    typedef struct packed {
        logic seek_none;
        logic hit;
        logic wrap;
        logic clr_last;
        logic zero_brush;
        logic upd_last;
        logic out_free;
    } rbpd_sts_t;

endpackage

>>> hdl/rectangle_brush_placement_decoder_core.sv
// Brush placement decoder: one rectangle-fill command for each brush record.
// s_* takes a record (size and colour) on a valid/ready beat; m_* returns the
// placement (row, column, clipped size, colour, frame_end) on a valid/ready
// beat. cfg_* writes image_width (index 0) or image_height (index 1); write
// it only while the block is idle. cfg_ready is always high.
// Each record takes a forward scan for an uncovered pixel, the placement, a
// write-back of each covered column of the placed rectangle (skipped for a
// zero-size brush), and a second forward scan before the result is loaded;
// a scan reads one column per step and takes an extra read step for each
// row wrap. A scan visits at most about three row widths, since a full row
// pass without a hit jumps to the row of the shallowest cover. A frame end
// adds a sweep that zeroes the per-column coverage memory over the columns
// touched in that frame. s_ready rises again in the cycle after the load, so
// one record is in flight; the coverage memory sets the pace.
// After reset the coverage memory is swept to zero before s_ready rises. The
// result sits in an output register: a stalled receiver holds that beat while
// the next record is already being placed; the block waits before loading a
// second result.
module rectangle_brush_placement_decoder_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rbpd_pkg::rbpd_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rbpd_pkg::rbpd_out_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rbpd_pkg::CFG_W-1:0]        cfg_data
);
    import rbpd_pkg::*;

    rbpd_cmd_t cmd;
    rbpd_sts_t sts;

    assign cfg_ready = 1'b1;

    rbpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rbpd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> hdl/rbpd_ram.sv
module rbpd_ram #(
    parameter int DATA_W = 13,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/rbpd_ctrl.sv
module rbpd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rbpd_pkg::rbpd_sts_t sts,
    output rbpd_pkg::rbpd_cmd_t cmd
);
    import rbpd_pkg::*;

    rbpd_state_t state_reg, state_next;
    logic        boot_reg, boot_next;
    logic        seek_end_reg, seek_end_next;
    logic        end_reg, end_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            boot_reg     <= 1'b1;
            seek_end_reg <= 1'b0;
            end_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            boot_reg     <= boot_next;
            seek_end_reg <= seek_end_next;
            end_reg      <= end_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        boot_next     = boot_reg;
        seek_end_next = seek_end_reg;
        end_next      = end_reg;
        cmd           = '0;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    if (boot_reg) begin
                        boot_next  = 1'b0;
                        state_next = ST_IDLE;
                    end else if (seek_end_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_PLACE;
                    end
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take      = 1'b1;
                    seek_end_next = 1'b0;
                    end_next      = 1'b0;
                    state_next    = ST_SEEK_INIT;
                end
            end
            ST_SEEK_INIT: begin
                cmd.seek_init = 1'b1;
                state_next    = ST_SEEK_RD;
            end
            ST_SEEK_RD: begin
                if (sts.seek_none) begin
                    // no uncovered pixel left: start a new frame
                    end_next   = seek_end_reg;
                    state_next = ST_CLEAR;
                end else begin
                    state_next = ST_SEEK_CHK;
                end
            end
            ST_SEEK_CHK: begin
                cmd.seek_chk = 1'b1;
                if (sts.hit) begin
                    state_next = seek_end_reg ? ST_OUT : ST_PLACE;
                end else if (sts.wrap) begin
                    state_next = ST_SEEK_RD;
                end
            end
            ST_PLACE: begin
                cmd.place     = 1'b1;
                seek_end_next = 1'b1;
                state_next    = sts.zero_brush ? ST_SEEK_INIT : ST_UPD_RD;
            end
            ST_UPD_RD: begin
                cmd.upd_rd = 1'b1;
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                cmd.upd_wr = 1'b1;
                if (sts.upd_last) begin
                    state_next = ST_SEEK_INIT;
                end
            end
            ST_OUT: begin
                cmd.frame_end = end_reg;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/rbpd_datapath.sv
module rbpd_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rbpd_pkg::rbpd_in_t                  s_data,
    input  logic                                cfg_valid,
    input  logic [rbpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rbpd_pkg::CFG_W-1:0]          cfg_data,
    input  rbpd_pkg::rbpd_cmd_t                 cmd,
    output rbpd_pkg::rbpd_sts_t                 sts,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rbpd_pkg::rbpd_out_t                 m_data
);
    import rbpd_pkg::*;

    logic [CFG_W-1:0] img_w_reg, img_w_next;
    logic [CFG_W-1:0] img_h_reg, img_h_next;
    logic [DIM_W-1:0] cur_row_reg, cur_row_next;
    logic [DIM_W-1:0] cur_col_reg, cur_col_next;
    logic             pass_full_reg, pass_full_next;
    logic [DIM_W-1:0] pass_min_reg, pass_min_next;
    logic [DIM_W-1:0] hwm_reg, hwm_next;
    logic [DIM_W-1:0] clr_reg, clr_next;
    logic [DIM_W-1:0] upd_col_reg, upd_col_next;
    logic             out_valid_reg, out_valid_next;

    rbpd_in_t         in_reg, in_next;
    logic [DIM_W-1:0] place_row_reg, place_row_next;
    logic [DIM_W-1:0] place_col_reg, place_col_next;
    logic [7:0]       fw_reg, fw_next;
    logic [7:0]       fh_reg, fh_next;
    logic [DIM_W-1:0] top_reg, top_next;
    logic [DIM_W-1:0] upd_end_reg, upd_end_next;
    rbpd_out_t        out_reg, out_next;

    logic [DIM_W-1:0] eff_w, eff_h;
    logic [DIM_W-1:0] col_inc, row_inc, upd_inc, min_new;
    logic [DIM_W-1:0] room_w, room_h, upd_end_c;
    logic [7:0]       fw_c, fh_c;

    logic             wr_en;
    logic [COL_AW-1:0] wr_addr, rd_addr;
    logic [DIM_W-1:0] wr_data, rd_data;

    rbpd_ram #(
        .DATA_W (DIM_W),
        .DEPTH  (MAX_WIDTH)
    ) u_cover (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // effective size: zero reads as one, oversize saturates
    always_comb begin
        if (img_w_reg == '0) begin
            eff_w = DIM_W'(1);
        end else if (32'(img_w_reg) > MAX_WIDTH) begin
            eff_w = DIM_W'(MAX_WIDTH);
        end else begin
            eff_w = DIM_W'(img_w_reg);
        end
        if (img_h_reg == '0) begin
            eff_h = DIM_W'(1);
        end else if (32'(img_h_reg) > MAX_HEIGHT) begin
            eff_h = DIM_W'(MAX_HEIGHT);
        end else begin
            eff_h = DIM_W'(img_h_reg);
        end
    end

    assign col_inc   = cur_col_reg + DIM_W'(1);
    assign row_inc   = cur_row_reg + DIM_W'(1);
    assign upd_inc   = upd_col_reg + DIM_W'(1);
    assign min_new   = (rd_data < pass_min_reg) ? rd_data : pass_min_reg;
    assign room_w    = eff_w - cur_col_reg;
    assign room_h    = eff_h - cur_row_reg;
    assign fw_c      = (DIM_W'(in_reg.brush_width) < room_w) ? in_reg.brush_width
                                                              : room_w[7:0];
    assign fh_c      = (DIM_W'(in_reg.brush_height) < room_h) ? in_reg.brush_height
                                                               : room_h[7:0];
    assign upd_end_c = cur_col_reg + DIM_W'(fw_c);

    always_comb begin
        sts.seek_none  = (cur_row_reg >= eff_h);
        sts.hit        = (rd_data <= cur_row_reg);
        sts.wrap       = (col_inc >= eff_w);
        sts.clr_last   = ((clr_reg + DIM_W'(1)) >= hwm_reg);
        sts.zero_brush = (in_reg.brush_width == '0) || (in_reg.brush_height == '0);
        sts.upd_last   = (upd_inc == upd_end_reg);
        sts.out_free   = !out_valid_reg || m_ready;
    end

    always_comb begin
        img_w_next     = img_w_reg;
        img_h_next     = img_h_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        pass_full_next = pass_full_reg;
        pass_min_next  = pass_min_reg;
        hwm_next       = hwm_reg;
        clr_next       = clr_reg;
        upd_col_next   = upd_col_reg;
        out_valid_next = out_valid_reg;
        in_next        = in_reg;
        place_row_next = place_row_reg;
        place_col_next = place_col_reg;
        fw_next        = fw_reg;
        fh_next        = fh_reg;
        top_next       = top_reg;
        upd_end_next   = upd_end_reg;
        out_next       = out_reg;
        rd_addr        = cur_col_reg[COL_AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = clr_reg[COL_AW-1:0];
        wr_data        = '0;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  img_w_next = cfg_data;
                CFG_IMAGE_HEIGHT: img_h_next = cfg_data;
                default: ;
            endcase
        end

        if (cmd.take) begin
            in_next = s_data;
        end

        if (cmd.seek_init) begin
            pass_min_next = '1;
            if (cur_col_reg >= eff_w) begin
                cur_col_next   = '0;
                cur_row_next   = row_inc;
                pass_full_next = 1'b1;
            end else begin
                pass_full_next = (cur_col_reg == '0);
            end
        end

        if (cmd.seek_chk && !sts.hit) begin
            if (sts.wrap) begin
                // after a full row pass with no hit, jump to the shallowest cover
                cur_col_next   = '0;
                cur_row_next   = (pass_full_reg && (min_new > row_inc)) ? min_new : row_inc;
                pass_full_next = 1'b1;
                pass_min_next  = '1;
            end else begin
                cur_col_next  = col_inc;
                pass_min_next = min_new;
                rd_addr       = col_inc[COL_AW-1:0];
            end
        end

        if (cmd.clr_step) begin
            wr_en   = 1'b1;
            wr_addr = clr_reg[COL_AW-1:0];
            wr_data = '0;
            if (sts.clr_last) begin
                clr_next     = '0;
                hwm_next     = '0;
                cur_row_next = '0;
                cur_col_next = '0;
            end else begin
                clr_next = clr_reg + DIM_W'(1);
            end
        end

        if (cmd.place) begin
            place_row_next = cur_row_reg;
            place_col_next = cur_col_reg;
            if (sts.zero_brush) begin
                fw_next      = '0;
                fh_next      = '0;
                cur_col_next = col_inc;
            end else begin
                fw_next      = fw_c;
                fh_next      = fh_c;
                top_next     = cur_row_reg + DIM_W'(fh_c);
                upd_col_next = cur_col_reg;
                upd_end_next = upd_end_c;
                if (upd_end_c > hwm_reg) begin
                    hwm_next = upd_end_c;
                end
            end
        end

        if (cmd.upd_rd) begin
            rd_addr = upd_col_reg[COL_AW-1:0];
        end

        if (cmd.upd_wr) begin
            // read the next column while this one is written back
            rd_addr      = upd_inc[COL_AW-1:0];
            upd_col_next = upd_inc;
            if (rd_data < top_reg) begin
                wr_en   = 1'b1;
                wr_addr = upd_col_reg[COL_AW-1:0];
                wr_data = top_reg;
            end
        end

        if (cmd.out_load) begin
            out_valid_next      = 1'b1;
            out_next.fill_row    = place_row_reg[11:0];
            out_next.fill_col    = place_col_reg[11:0];
            out_next.fill_width  = fw_reg;
            out_next.fill_height = fh_reg;
            out_next.fill_red    = in_reg.red;
            out_next.fill_green  = in_reg.green;
            out_next.fill_blue   = in_reg.blue;
            out_next.frame_end   = cmd.frame_end;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg     <= IMAGE_WIDTH_RST;
            img_h_reg     <= IMAGE_HEIGHT_RST;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            pass_full_reg <= 1'b0;
            pass_min_reg  <= '1;
            hwm_reg       <= DIM_W'(MAX_WIDTH);
            clr_reg       <= '0;
            upd_col_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            img_w_reg     <= img_w_next;
            img_h_reg     <= img_h_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            pass_full_reg <= pass_full_next;
            pass_min_reg  <= pass_min_next;
            hwm_reg       <= hwm_next;
            clr_reg       <= clr_next;
            upd_col_reg   <= upd_col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg        <= in_next;
        place_row_reg <= place_row_next;
        place_col_reg <= place_col_next;
        fw_reg        <= fw_next;
        fh_reg        <= fh_next;
        top_reg       <= top_next;
        upd_end_reg   <= upd_end_next;
        out_reg       <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> sim/rectangle_brush_placement_decoder_core_tb.sv
module rectangle_brush_placement_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbpd_pkg::*;

    typedef enum logic [1:0] {
        ROW_BEAT,
        ROW_SIZE
    } row_kind_t;

    typedef enum logic [1:0] {
        DRAIN_FULL,
        DRAIN_COIN,
        DRAIN_EVERY4,
        DRAIN_TRICKLE
    } drain_mode_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [CFG_W-1:0] width_val;
        logic [CFG_W-1:0] height_val;
        rbpd_in_t         rec;
        logic             typed;
        rbpd_out_t        want;
    } plan_row_t;

    // Typed rows carry their result; the others go through the placement predictor.
    localparam plan_row_t DIRECTED_PLAN [0:21] = '{
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd255, 8'd255, 8'hff, 8'h00, 8'ha5}, 1'b1,
          '{12'd0, 12'd0, 8'd255, 8'd255, 8'hff, 8'h00, 8'ha5, 1'b0}},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd0, 8'd7, 8'h01, 8'h02, 8'h03}, 1'b1,
          '{12'd0, 12'd255, 8'd0, 8'd0, 8'h01, 8'h02, 8'h03, 1'b0}},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd9, 8'd0, 8'h80, 8'h40, 8'h20}, 1'b1,
          '{12'd0, 12'd256, 8'd0, 8'd0, 8'h80, 8'h40, 8'h20, 1'b0}},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd0, 8'd0, 8'h7f, 8'hfe, 8'h01}, 1'b1,
          '{12'd0, 12'd257, 8'd0, 8'd0, 8'h7f, 8'hfe, 8'h01, 1'b0}},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd1, 8'd1, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{12'd0, 12'd258, 8'd1, 8'd1, 8'h00, 8'h00, 8'h00, 1'b0}},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd255, 8'd255, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd255, 8'd128, 8'h55, 8'haa, 8'h55}, 1'b0, '0},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd200, 8'd3, 8'haa, 8'h55, 8'haa}, 1'b0, '0},
        '{ROW_SIZE, 13'd0, 13'd0, '0, 1'b0, '0},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd5, 8'd5, 8'h12, 8'h34, 8'h56}, 1'b0, '0},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd5, 8'd5, 8'hff, 8'hff, 8'hff}, 1'b1,
          '{12'd0, 12'd0, 8'd1, 8'd1, 8'hff, 8'hff, 8'hff, 1'b1}},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd0, 8'd3, 8'h00, 8'hff, 8'h00}, 1'b1,
          '{12'd0, 12'd0, 8'd0, 8'd0, 8'h00, 8'hff, 8'h00, 1'b1}},
        '{ROW_SIZE, 13'd8191, 13'd8191, '0, 1'b0, '0},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd255, 8'd255, 8'hc3, 8'h3c, 8'h96}, 1'b1,
          '{12'd0, 12'd0, 8'd255, 8'd255, 8'hc3, 8'h3c, 8'h96, 1'b0}},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd255, 8'd1, 8'h01, 8'h80, 8'hfe}, 1'b0, '0},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd17, 8'd200, 8'h5a, 8'ha5, 8'h0f}, 1'b0, '0},
        '{ROW_SIZE, 13'd4096, 13'd1, '0, 1'b0, '0},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd255, 8'd255, 8'hf0, 8'h0f, 8'h33}, 1'b0, '0},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd0, 8'd1, 8'hcc, 8'h99, 8'h66}, 1'b0, '0},
        '{ROW_SIZE, 13'd3, 13'd4096, '0, 1'b0, '0},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd255, 8'd255, 8'h11, 8'h22, 8'h44}, 1'b0, '0},
        '{ROW_BEAT, 13'd0, 13'd0, '{8'd2, 8'd9, 8'h88, 8'h77, 8'hee}, 1'b0, '0}
    };

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    rbpd_in_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    rbpd_out_t        m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data  = '0;

    // placement predictor state
    int unsigned      cover_depth [MAX_WIDTH];
    int unsigned      cur_row;
    int unsigned      cur_col;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    rbpd_out_t        fill_expect_q [$];
    rbpd_out_t        fill_want;
    int unsigned      fail_count;

    int unsigned      burst_left;
    int unsigned      random_sent;
    int unsigned      phase_len;

    drain_mode_t      drain_mode;
    int unsigned      drain_left;
    int unsigned      drain_tick;
    logic             drain_next;

    rectangle_brush_placement_decoder_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned lim);
        if (v == '0) return 1;
        if (32'(v) > lim) return lim;
        return 32'(v);
    endfunction

    function automatic void clear_coverage();
        foreach (cover_depth[i]) cover_depth[i] = 0;
        cur_row = 0;
        cur_col = 0;
    endfunction

    // Advance the cursor to the next uncovered pixel; 0 when the frame is full.
    function automatic bit find_uncovered(int unsigned w, int unsigned h);
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
        end
        while (cur_row < h) begin
            if (cover_depth[cur_col] <= cur_row) return 1'b1;
            cur_col++;
            if (cur_col >= w) begin
                cur_col = 0;
                cur_row++;
            end
        end
        return 1'b0;
    endfunction

    function automatic rbpd_out_t place_brush(rbpd_in_t rec);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned fw;
        int unsigned fh;
        rbpd_out_t   res;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        if (!find_uncovered(w, h)) clear_coverage();
        r = cur_row;
        c = cur_col;
        if (rec.brush_width == '0 || rec.brush_height == '0) begin
            fw = 0;
            fh = 0;
            cur_col++;
        end else begin
            fw = (32'(rec.brush_width) < w - c) ? 32'(rec.brush_width) : w - c;
            fh = (32'(rec.brush_height) < h - r) ? 32'(rec.brush_height) : h - r;
            for (int unsigned k = 0; k < fw; k++) begin
                if (cover_depth[c + k] < r + fh) cover_depth[c + k] = r + fh;
            end
        end
        res.frame_end = !find_uncovered(w, h);
        if (res.frame_end) clear_coverage();
        res.fill_row    = r[11:0];
        res.fill_col    = c[11:0];
        res.fill_width  = fw[7:0];
        res.fill_height = fh[7:0];
        res.fill_red    = rec.red;
        res.fill_green  = rec.green;
        res.fill_blue   = rec.blue;
        return res;
    endfunction

    function automatic rbpd_in_t random_brush();
        rbpd_in_t    rec;
        int unsigned sel;
        int unsigned wcap;
        int unsigned hcap;
        sel  = $urandom_range(0, 9);
        wcap = clamp_size(width_reg, MAX_WIDTH);
        hcap = clamp_size(height_reg, MAX_HEIGHT);
        wcap = (wcap > 255) ? 255 : wcap;
        hcap = (hcap > 255) ? 255 : hcap;
        // keep some brushes well under the frame so frames take several beats
        if (sel < 6) begin
            wcap = (wcap / 3 == 0) ? 1 : wcap / 3;
            hcap = (hcap / 3 == 0) ? 1 : hcap / 3;
        end
        rec.red   = 8'($urandom_range(0, 255));
        rec.green = 8'($urandom_range(0, 255));
        rec.blue  = 8'($urandom_range(0, 255));
        if (sel == 0) begin
            rec.brush_width  = 8'($urandom_range(0, 255));
            rec.brush_height = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 2))
                0: rec.brush_width = 8'd0;
                1: rec.brush_height = 8'd0;
                default: begin
                    rec.brush_width  = 8'd0;
                    rec.brush_height = 8'd0;
                end
            endcase
        end else if (sel <= 2) begin
            rec.brush_width  = 8'($urandom_range(0, 255));
            rec.brush_height = 8'($urandom_range(0, 255));
        end else begin
            rec.brush_width  = 8'($urandom_range(1, wcap));
            rec.brush_height = 8'($urandom_range(1, hcap));
        end
        return rec;
    endfunction

    // Present one record, hold it until accepted, then maybe open a gap.
    task automatic send_record(input rbpd_in_t rec, input logic typed, input rbpd_out_t want);
        rbpd_out_t predicted;
        s_valid <= 1'b1;
        s_data  <= rec;
        do @(posedge aclk); while (!s_ready);
        predicted = place_brush(rec);
        fill_expect_q.push_back(typed ? want : predicted);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    // Drain everything outstanding, then write the size registers.
    task automatic write_size(input logic set_w, input logic [CFG_W-1:0] w_val,
                              input logic set_h, input logic [CFG_W-1:0] h_val);
        s_valid <= 1'b0;
        while (fill_expect_q.size() != 0 || !s_ready) @(posedge aclk);
        if (set_w) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IMAGE_WIDTH;
            cfg_data  <= w_val;
            do @(posedge aclk); while (!cfg_ready);
            width_reg = w_val;
        end
        if (set_h) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IMAGE_HEIGHT;
            cfg_data  <= h_val;
            do @(posedge aclk); while (!cfg_ready);
            height_reg = h_val;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Result side: check each beat against the oldest expectation, stall on a pattern.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (fill_expect_q.size() == 0) begin
                    $display("%0t: fill beat with nothing expected, got %p",
                             $time, m_data);
                    fail_count++;
                end else begin
                    fill_want = fill_expect_q.pop_front();
                    check_field("fill_row", fill_want.fill_row, m_data.fill_row);
                    check_field("fill_col", fill_want.fill_col, m_data.fill_col);
                    check_field("fill_width", 12'(fill_want.fill_width),
                                12'(m_data.fill_width));
                    check_field("fill_height", 12'(fill_want.fill_height),
                                12'(m_data.fill_height));
                    check_field("fill_red", 12'(fill_want.fill_red),
                                12'(m_data.fill_red));
                    check_field("fill_green", 12'(fill_want.fill_green),
                                12'(m_data.fill_green));
                    check_field("fill_blue", 12'(fill_want.fill_blue),
                                12'(m_data.fill_blue));
                    check_field("frame_end", 12'(fill_want.frame_end),
                                12'(m_data.frame_end));
                end
            end
            if (drain_left == 0) begin
                drain_mode = drain_mode_t'($urandom_range(0, 3));
                drain_left = $urandom_range(32, 256);
            end else begin
                drain_left--;
            end
            drain_tick++;
            case (drain_mode)
                DRAIN_FULL:   drain_next = 1'b1;
                DRAIN_COIN:   drain_next = 1'($urandom_range(0, 1));
                DRAIN_EVERY4: drain_next = (drain_tick % 4 == 0);
                default:      drain_next = ($urandom_range(0, 7) == 0);
            endcase
            m_ready <= drain_next;
        end
    end

    initial begin
        fail_count  = 0;
        burst_left  = 0;
        random_sent = 0;
        drain_mode  = DRAIN_FULL;
        drain_left  = 0;
        drain_tick  = 0;
        width_reg   = IMAGE_WIDTH_RST;
        height_reg  = IMAGE_HEIGHT_RST;
        clear_coverage();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        // hold off until the coverage sweep after reset is done
        do @(posedge aclk); while (!s_ready);

        foreach (DIRECTED_PLAN[i]) begin
            if (DIRECTED_PLAN[i].kind == ROW_SIZE)
                write_size(1'b1, DIRECTED_PLAN[i].width_val,
                           1'b1, DIRECTED_PLAN[i].height_val);
            else
                send_record(DIRECTED_PLAN[i].rec, DIRECTED_PLAN[i].typed,
                            DIRECTED_PLAN[i].want);
        end

        // Random phases; sizes change mid-frame so the kept cursor gets exercised.
        while (random_sent < 1100) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    write_size(1'b1, CFG_W'($urandom_range(1, 40)),
                               1'b1, CFG_W'($urandom_range(1, 40)));
                    phase_len = $urandom_range(60, 100);
                end
                5: begin
                    write_size(1'b1, CFG_W'($urandom_range(0, 1)),
                               1'b1, CFG_W'($urandom_range(0, 8)));
                    phase_len = 30;
                end
                6: begin
                    write_size(1'b1, CFG_W'($urandom_range(0, 1) ? 4096
                                                                 : $urandom_range(4097, 8191)),
                               1'b1, CFG_W'($urandom_range(1, 3)));
                    phase_len = 24;
                end
                7: begin
                    write_size(1'b1, CFG_W'($urandom_range(1, 8)),
                               1'b1, CFG_W'($urandom_range(100, 4096)));
                    phase_len = 40;
                end
                8: begin
                    write_size(1'b1, CFG_W'($urandom_range(0, 8191)),
                               1'b1, CFG_W'($urandom_range(0, 8191)));
                    phase_len = 12;
                end
                default: begin
                    if ($urandom_range(0, 1))
                        write_size(1'b1, CFG_W'($urandom_range(1, 40)), 1'b0, '0);
                    else
                        write_size(1'b0, '0, 1'b1, CFG_W'($urandom_range(1, 40)));
                    phase_len = 40;
                end
            endcase
            repeat (phase_len) begin
                send_record(random_brush(), 1'b0, '0);
                random_sent++;
            end
        end

        s_valid <= 1'b0;
        while (fill_expect_q.size() != 0) @(posedge aclk);
        repeat (500) @(posedge aclk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #200ms;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/rbpd_pkg.sv
hdl/rbpd_ram.sv
hdl/rbpd_ctrl.sv
hdl/rbpd_datapath.sv
hdl/rectangle_brush_placement_decoder_core.sv
sim/rectangle_brush_placement_decoder_core_tb.sv
